@@ design/mtg_pkg.sv @@
// shared constants and tempering function for the mt19937 word generator
`default_nettype none
package mtg_pkg;

    localparam int unsigned N_WORDS   = 624;
    localparam int unsigned M_SHIFT   = 397;
    localparam int unsigned ADDR_W    = $clog2(N_WORDS);
    localparam int unsigned WORD_W    = 32;

    localparam logic [WORD_W-1:0] MATRIX     = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] INIT_MUL   = 32'h6c07_8965;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

    // output tempering, four xor-shift steps
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

@@ design/mtg_req_if.sv @@
// request channel carrying the restart flag
`default_nettype none
interface mtg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

@@ design/mtg_word_if.sv @@
// result channel carrying one tempered word
`default_nettype none
interface mtg_word_if;
    logic                           valid;
    logic                           ready;
    logic [mtg_pkg::WORD_W-1:0]     random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

@@ design/mtg_cfg_if.sv @@
// configuration write channel for the seed register
`default_nettype none
interface mtg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mtg_pkg::WORD_W-1:0]     seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink   (input valid, input seed_value, output ready);
endinterface
`default_nettype wire

@@ design/mt19937_word_generator.sv @@
// mt19937 word generator top level: sequencer, state ram, seeding multiplier
// a word from the live state is read in the read-issue state, then tempered into
//   the output register in the read-data state, which waits while that register
//   is full; ready returns with the word; seeding does one registered multiply
//   and one ram write per word; each twist over the whole array uses one ram read port
// reset: seed register to 5489, position to 624, not seeded; the state array is
//   not cleared, the first request seeds it before any read
`default_nettype none
module mt19937_word_generator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mtg_req_if.sink     i_req,
    mtg_cfg_if.sink     i_cfg,
    mtg_word_if.source  o_word
);

    localparam int unsigned AW = mtg_pkg::ADDR_W;
    localparam int unsigned WW = mtg_pkg::WORD_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(mtg_pkg::N_WORDS - 1);
    localparam logic [AW:0]   N_EXT    = (AW+1)'(mtg_pkg::N_WORDS);

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SEED_MUL = 9'b000000010,
        ST_SEED_WR  = 9'b000000100,
        ST_TW_RD0   = 9'b000001000,
        ST_TW_CUR   = 9'b000010000,
        ST_TW_NXT   = 9'b000100000,
        ST_TW_WR    = 9'b001000000,
        ST_RD_ISSUE = 9'b010000000,
        ST_RD_DATA  = 9'b100000000
    } t_state;

    t_state         r_state, n_state;
    logic [WW-1:0]  r_seed;
    logic [AW-1:0]  r_pos, n_pos;          // read position, 624 means exhausted
    logic           r_seeded, n_seeded;
    logic [AW-1:0]  r_idx, n_idx;          // seeding / twist loop index
    logic [WW-1:0]  r_prev, n_prev;        // last seeded word
    logic [WW-1:0]  r_cur, n_cur;          // old state[i] during twist
    logic [WW-1:0]  r_nxt, n_nxt;          // state[i+1] during twist
    logic           r_out_valid, n_out_valid;
    logic [WW-1:0]  r_out_data, n_out_data;

    // ram ports
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [WW-1:0]  wr_data, rd_data;

    // multiplier
    logic           mul_en;
    logic [WW-1:0]  mul_prod;

    // twist helpers
    logic [AW:0]    far_sum, step_sum;
    logic [AW-1:0]  far_idx, ahead_idx;
    logic [WW-1:0]  tw_y, tw_v;
    logic           req_xfer, out_free;

    mtg_ram #(
        .WIDTH (WW),
        .DEPTH (mtg_pkg::N_WORDS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mtg_seed_mul u_seed_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_x    (r_prev),
        .o_prod (mul_prod)
    );

    // handshakes
    assign i_req.ready    = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_word.valid   = r_out_valid;
    assign o_word.random_word = r_out_data;

    assign req_xfer = i_req.valid & i_req.ready;
    assign out_free = ~r_out_valid | o_word.ready;

    // index i+397 and i+2, both wrapped at 624
    assign far_sum   = {1'b0, r_idx} + (AW+1)'(mtg_pkg::M_SHIFT);
    assign far_idx   = (far_sum >= N_EXT) ? AW'(far_sum - N_EXT) : far_sum[AW-1:0];
    assign step_sum  = {1'b0, r_idx} + (AW+1)'(2);
    assign ahead_idx = (step_sum >= N_EXT) ? AW'(step_sum - N_EXT) : step_sum[AW-1:0];

    // twist of one word, far word arrives on the ram read data
    assign tw_y = (r_cur & mtg_pkg::UPPER_MASK) | (r_nxt & mtg_pkg::LOWER_MASK);
    assign tw_v = rd_data ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::MATRIX : '0);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_seeded    = r_seeded;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = tw_v;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        mul_en      = 1'b0;

        // result taken by the consumer
        if (r_out_valid && o_word.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    if (i_req.restart || !r_seeded) begin
                        // state[0] is the seed itself
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = r_seed;
                        n_prev   = r_seed;
                        n_idx    = AW'(1);
                        n_seeded = 1'b1;
                        n_pos    = AW'(mtg_pkg::N_WORDS);
                        n_state  = ST_SEED_MUL;
                    end else if ({1'b0, r_pos} >= N_EXT) begin
                        n_state = ST_TW_RD0;
                    end else begin
                        n_state = ST_RD_ISSUE;
                    end
                end
            end
            ST_SEED_MUL: begin
                mul_en  = 1'b1;
                n_state = ST_SEED_WR;
            end
            ST_SEED_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = mul_prod + WW'(r_idx);
                n_prev  = mul_prod + WW'(r_idx);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_TW_RD0;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_SEED_MUL;
                end
            end
            ST_TW_RD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_idx   = '0;
                n_state = ST_TW_CUR;
            end
            ST_TW_CUR: begin
                // state[0] in hand, fetch state[1]
                n_cur   = rd_data;
                rd_en   = 1'b1;
                rd_addr = AW'(1);
                n_state = ST_TW_NXT;
            end
            ST_TW_NXT: begin
                // state[i+1] in hand, fetch state[i+397]
                n_nxt   = rd_data;
                rd_en   = 1'b1;
                rd_addr = far_idx;
                n_state = ST_TW_WR;
            end
            ST_TW_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = tw_v;
                n_cur   = r_nxt;
                if (r_idx == LAST_IDX) begin
                    n_pos   = '0;
                    n_state = ST_RD_ISSUE;
                end else begin
                    // wrap read of word 0 sees its new value, as the sweep requires
                    rd_en   = 1'b1;
                    rd_addr = ahead_idx;
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_TW_NXT;
                end
            end
            ST_RD_ISSUE: begin
                rd_en   = 1'b1;
                rd_addr = r_pos;
                n_pos   = r_pos + AW'(1);
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                // ram data holds until the output slot frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mtg_pkg::temper(rd_data);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= mtg_pkg::SEED_RESET;
            r_pos       <= AW'(mtg_pkg::N_WORDS);
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_seed <= i_cfg.seed_value;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

@@ design/mtg_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]          i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]               o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ design/mtg_seed_mul.sv @@
// registered seeding multiplier: init_mul * (x ^ (x >> 30))
`default_nettype none
module mtg_seed_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [mtg_pkg::WORD_W-1:0]    i_x,
    output logic [mtg_pkg::WORD_W-1:0]         o_prod
);

    logic [mtg_pkg::WORD_W-1:0] r_prod;
    logic [mtg_pkg::WORD_W-1:0] mix;

    assign mix = i_x ^ (i_x >> 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mtg_pkg::INIT_MUL * mix;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire
